>>> hdl/nibble_wildcard_pattern_search_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nibble wildcard pattern search unit
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef NIBBLE_WILDCARD_PATTERN_SEARCH_UNIT_ASSERT_SVH
`define NIBBLE_WILDCARD_PATTERN_SEARCH_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define NWPS_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication
`define NWPS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`else

`define NWPS_ASSERT_IMPL(label, clk, rst_n, pre, post)
`define NWPS_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

>>> hdl/nwps_pkg.sv
// ----------------------------------------------------------------------------
// nwps_pkg
// Shared types and constants of the nibble wildcard pattern search unit.
// ----------------------------------------------------------------------------
package nwps_pkg;

    // default window depth in bytes
    localparam int MAX_PATTERN_BYTES_DEF = 8;

    // pattern bytes held in the registers; later bytes are wildcards
    localparam int PATTERN_REG_BYTES = 8;
    localparam int PAT_IDX_W         = $clog2(PATTERN_REG_BYTES);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_NIBBLES  = 3'd0,
        REG_NIBBLE_CARE_MASK = 3'd1,
        REG_PATTERN_LENGTH   = 3'd2,
        REG_BASE_OFFSET      = 3'd3
    } cfg_reg_t;

    // pattern as seen by every cell
    typedef struct packed {
        logic [PATTERN_REG_BYTES-1:0][1:0] care;
        logic [PATTERN_REG_BYTES-1:0][7:0] nibbles;
    } pattern_cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } in_word_t;

    typedef struct packed {
        logic        match;
        logic [31:0] match_offset;
        logic        already_found;
    } out_word_t;

endpackage

>>> hdl/nwps_cell.sv
// ----------------------------------------------------------------------------
// nwps_cell
// One window byte: shifts towards the older end on every accepted word and
// compares its incoming byte with the pattern byte that lines up with it.
// ----------------------------------------------------------------------------
module nwps_cell
    import nwps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
    parameter int CELL_INDEX        = 0,
    localparam int LEN_W            = $clog2(MAX_PATTERN_BYTES + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift_en,
    input  logic             clear,
    input  logic [7:0]       shift_in,
    input  pattern_cfg_t     pattern,
    input  logic [LEN_W-1:0] eff_len,
    output logic [7:0]       byte_q,
    output logic             agree
);

    logic [7:0]       byte_reg;
    logic [7:0]       byte_next;
    logic             active;
    logic [LEN_W-1:0] diff;
    logic [LEN_W+3:0] diff_ext;
    logic             in_regs;
    logic [PAT_IDX_W-1:0] sel;
    logic             hi_ok;
    logic             lo_ok;

    // restart empties the window before the shift
    assign byte_next = clear ? 8'h00 : shift_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'h00;
        end
        else if (shift_en)
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_q = byte_reg;

    // this cell lines up with pattern byte eff_len-1-index
    assign active   = eff_len > LEN_W'(CELL_INDEX);
    assign diff     = eff_len - LEN_W'(CELL_INDEX) - LEN_W'(1);
    assign diff_ext = {4'b0000, diff};
    assign in_regs  = diff_ext < (LEN_W + 4)'(PATTERN_REG_BYTES);
    assign sel      = diff_ext[PAT_IDX_W-1:0];

    // nibble compares, care bit 0 is a wildcard
    assign hi_ok = !pattern.care[sel][1] || (byte_next[7:4] == pattern.nibbles[sel][7:4]);
    assign lo_ok = !pattern.care[sel][0] || (byte_next[3:0] == pattern.nibbles[sel][3:0]);

    assign agree = !active || !in_regs || (hi_ok && lo_ok);

endmodule

>>> hdl/nwps_out_buf.sv
// ----------------------------------------------------------------------------
// nwps_out_buf
// Output register with a skid stage, so a word is taken while the previous
// result still waits downstream.
// ----------------------------------------------------------------------------
module nwps_out_buf
    import nwps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_word_t push_data,
    output logic      full,
    output logic      out_valid,
    output out_word_t out_data,
    input  logic      out_stall
);

    logic      out_valid_reg;
    logic      skid_valid_reg;
    out_word_t out_data_reg;
    out_word_t skid_data_reg;
    logic      out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= skid_valid_reg && push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg  <= skid_data_reg;
                skid_data_reg <= push_data;
            end
            else
            begin
                out_data_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> hdl/nibble_wildcard_pattern_search_unit.sv
// ----------------------------------------------------------------------------
// nibble_wildcard_pattern_search_unit
// Sliding-window wildcard byte pattern search over a byte stream.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the skid stage is empty; the window is
// a chain of byte cells that all compare in parallel, and a skid stage keeps
// input open while a result waits. Result words leave from a registered stage.
// Reset: asynchronous, active low; clears window, count, found flag, registers
// (pattern length to one) and the output stage.
// ----------------------------------------------------------------------------
`include "nibble_wildcard_pattern_search_unit_assert.svh"

module nibble_wildcard_pattern_search_unit
    import nwps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  in_word_t               byte_data,
    output logic                   result_valid,
    input  logic                   result_stall,
    output out_word_t              result_data
);

    localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int CMP_W = (LEN_W > 4) ? LEN_W : 4;

    logic [63:0] pattern_nibbles_reg;
    logic [15:0] care_mask_reg;
    logic [3:0]  pattern_length_reg;
    logic [31:0] base_offset_reg;
    logic [31:0] bytes_seen_reg;
    logic [31:0] bytes_seen_next;
    logic        found_reg;
    logic        found_next;

    pattern_cfg_t     pattern;
    logic [CMP_W-1:0] len_ext;
    logic [LEN_W-1:0] eff_len;
    logic             accept;
    logic             prior_found;
    logic             hit;
    out_word_t        result;

    logic [MAX_PATTERN_BYTES-1:0][7:0] cell_byte;
    logic [MAX_PATTERN_BYTES-1:0]      cell_agree;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_nibbles_reg <= 64'd0;
            care_mask_reg       <= 16'd0;
            pattern_length_reg  <= 4'd1;
            base_offset_reg     <= 32'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PATTERN_NIBBLES:  pattern_nibbles_reg <= cfg_data;
                REG_NIBBLE_CARE_MASK: care_mask_reg       <= cfg_data[15:0];
                REG_PATTERN_LENGTH:   pattern_length_reg  <= cfg_data[3:0];
                REG_BASE_OFFSET:      base_offset_reg     <= cfg_data[31:0];
                default:              ;
            endcase
        end
    end

    assign pattern.nibbles = pattern_nibbles_reg;
    assign pattern.care    = care_mask_reg;

    // length clamped to 1..MAX_PATTERN_BYTES
    assign len_ext = CMP_W'(pattern_length_reg);

    always_comb
    begin
        if (len_ext == CMP_W'(0))
        begin
            eff_len = LEN_W'(1);
        end
        else if (len_ext > CMP_W'(MAX_PATTERN_BYTES))
        begin
            eff_len = LEN_W'(MAX_PATTERN_BYTES);
        end
        else
        begin
            eff_len = LEN_W'(len_ext);
        end
    end

    assign accept = byte_valid && !byte_stall;

    // window cells, cell 0 holds the newest byte
    for (genvar j = 0; j < MAX_PATTERN_BYTES; j++)
    begin : g_cell
        logic [7:0] shift_in;
        logic       clear;

        if (j == 0)
        begin : g_head
            assign shift_in = byte_data.data_byte;
            assign clear    = 1'b0;
        end
        else
        begin : g_body
            assign shift_in = cell_byte[j-1];
            assign clear    = byte_data.restart;
        end

        nwps_cell #(
            .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
            .CELL_INDEX        (j)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (accept),
            .clear    (clear),
            .shift_in (shift_in),
            .pattern  (pattern),
            .eff_len  (eff_len),
            .byte_q   (cell_byte[j]),
            .agree    (cell_agree[j])
        );
    end

    // count and found flag as they stand after this byte
    always_comb
    begin
        if (byte_data.restart)
        begin
            bytes_seen_next = 32'd1;
        end
        else if (bytes_seen_reg == 32'hFFFF_FFFF)
        begin
            bytes_seen_next = bytes_seen_reg;
        end
        else
        begin
            bytes_seen_next = bytes_seen_reg + 32'd1;
        end
    end

    assign prior_found = byte_data.restart ? 1'b0 : found_reg;
    assign hit         = !prior_found && (bytes_seen_next >= 32'(eff_len)) && (&cell_agree);
    assign found_next  = prior_found || hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg <= 32'd0;
            found_reg      <= 1'b0;
        end
        else if (accept)
        begin
            bytes_seen_reg <= bytes_seen_next;
            found_reg      <= found_next;
        end
    end

    // result word
    assign result.match         = hit;
    assign result.match_offset  = hit ? (base_offset_reg + (bytes_seen_next - 32'(eff_len)))
                                      : 32'd0;
    assign result.already_found = prior_found;

    nwps_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .full      (byte_stall),
        .out_valid (result_valid),
        .out_data  (result_data),
        .out_stall (result_stall)
    );

    // checks
    `NWPS_ASSERT_IMPL(a_match_first, clk, rst_n,
        result_valid && result_data.match, !result_data.already_found)
    `NWPS_ASSERT_IMPL(a_offset_zero, clk, rst_n,
        result_valid && !result_data.match, result_data.match_offset == 32'd0)
    `NWPS_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, byte_stall, result_valid)
    `NWPS_ASSERT_NEXT(a_found_sticks, clk, rst_n,
        found_reg && !(accept && byte_data.restart), found_reg)

endmodule

>>> dv/tb_nibble_wildcard_pattern_search_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nibble_wildcard_pattern_search_unit
// Self-checking bench for the wildcard byte pattern search unit. A cycle-free
// predictor of the window, byte count and found flag runs beside the block.
// Each accepted byte queues the result word it should give. Every result word
// is compared field by field with the oldest queued prediction. Directed cases
// come first, then random phases over several register settings, with random
// gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_nibble_wildcard_pattern_search_unit;

    import nwps_pkg::*;

    localparam int WIN_BYTES = MAX_PATTERN_BYTES_DEF;

    // register index past the end of the list; writes to it must be dropped
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE = 3'd6;

    // two pattern bytes used in the directed cases
    localparam logic [7:0] PAT_LEAD_BYTE  = 8'h37;
    localparam logic [7:0] PAT_TRAIL_BYTE = 8'h0f;

    localparam int PHASE_COUNT = 10;
    localparam int PHASE_WORDS = 143;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   byte_valid;
    logic                   byte_stall;
    in_word_t               byte_data;
    logic                   result_valid;
    logic                   result_stall;
    out_word_t              result_data;

    // predictor copy of the registers
    logic [63:0] pat_bytes;
    logic [15:0] care_bits;
    logic [3:0]  pat_len_reg;
    logic [31:0] base_off;

    // predictor copy of the search state
    logic [7:0]  win_hist [0:WIN_BYTES-1];
    logic [31:0] count_seen;
    logic        found_seen;

    out_word_t   search_expect_q [$];
    int          err_count;
    int          bytes_sent;
    int          results_seen;
    bit          idle_on;

    nibble_wildcard_pattern_search_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    // clock, 4 ns period
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int unsigned window_span();
        int unsigned span;
        span = 32'(pat_len_reg);
        if (span < 1)
            span = 1;
        if (span > WIN_BYTES)
            span = WIN_BYTES;
        return span;
    endfunction

    // true when byte b agrees with pattern byte k on every cared nibble
    function automatic bit byte_fits(input int unsigned k, input logic [7:0] b);
        if (k >= PATTERN_REG_BYTES)
            return 1'b1;
        if (care_bits[2*k+1] && b[7:4] != pat_bytes[8*k+4 +: 4])
            return 1'b0;
        if (care_bits[2*k] && b[3:0] != pat_bytes[8*k +: 4])
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic out_word_t predict_search(input in_word_t w);
        out_word_t   r;
        int unsigned span;
        int          i;
        bit          ok;
        r = '0;
        if (w.restart)
        begin
            for (i = 0; i < WIN_BYTES; i++)
                win_hist[i] = 8'h00;
            count_seen = '0;
            found_seen = 1'b0;
        end
        for (i = WIN_BYTES - 1; i > 0; i--)
            win_hist[i] = win_hist[i-1];
        win_hist[0] = w.data_byte;
        if (count_seen != 32'hFFFF_FFFF)
            count_seen++;
        span = window_span();
        r.already_found = found_seen;
        if (!found_seen && count_seen >= span)
        begin
            ok = 1'b1;
            for (i = 0; i < span; i++)
                if (!byte_fits(i, win_hist[span-1-i]))
                    ok = 1'b0;
            if (ok)
            begin
                r.match        = 1'b1;
                r.match_offset = base_off + (count_seen - span);
                found_seen     = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic void model_config(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_PATTERN_NIBBLES:  pat_bytes   = val;
            REG_NIBBLE_CARE_MASK: care_bits   = val[15:0];
            REG_PATTERN_LENGTH:   pat_len_reg = val[3:0];
            REG_BASE_OFFSET:      base_off    = val[31:0];
            default: ;
        endcase
    endfunction

    // random byte that satisfies pattern byte k
    function automatic logic [7:0] fit_pattern_byte(input int unsigned k);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (k < PATTERN_REG_BYTES)
        begin
            if (care_bits[2*k])
                b[3:0] = pat_bytes[8*k +: 4];
            if (care_bits[2*k+1])
                b[7:4] = pat_bytes[8*k+4 +: 4];
        end
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus and checking helpers
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR result %0d: %s got %h expected %h", results_seen, what, got, want);
        err_count++;
    endtask

    // called at a rising edge; leaves valid high after acceptance
    task automatic send_byte(input logic [7:0] b, input logic rs);
        in_word_t w;
        int       gap;
        bit       taken;
        w.data_byte = b;
        w.restart   = rs;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap != 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= w;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = (byte_stall === 1'b0);
            if (taken)
                search_expect_q.insert(search_expect_q.size(), predict_search(w));
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    // drop valid in the step of the last acceptance, then wait for every result
    task automatic settle_idle();
        byte_valid <= 1'b0;
        while (search_expect_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        model_config(idx, val);
        @(posedge clk);
    endtask

    task automatic check_result(input out_word_t got);
        out_word_t want;
        results_seen++;
        if (search_expect_q.size() == 0)
        begin
            report_mismatch("word with nothing pending, offset", got.match_offset, '0);
            return;
        end
        want = search_expect_q.pop_front();
        if (got.match !== want.match)
            report_mismatch("match", 32'(got.match), 32'(want.match));
        if (got.match_offset !== want.match_offset)
            report_mismatch("match_offset", got.match_offset, want.match_offset);
        if (got.already_found !== want.already_found)
            report_mismatch("already_found", 32'(got.already_found),
                            32'(want.already_found));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset values: length one, no care bits, so the first byte matches
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b1);
    endtask

    // over-long length acts as full window; no match before eight bytes
    task automatic test_short_stream();
        int i;
        settle_idle();
        write_reg(REG_PATTERN_NIBBLES, '1);
        write_reg(REG_NIBBLE_CARE_MASK, 64'h0);
        write_reg(REG_PATTERN_LENGTH, 64'd15);
        write_reg(REG_BASE_OFFSET, 64'h0);
        send_byte(8'hFF, 1'b1);
        for (i = 1; i < WIN_BYTES; i++)
            send_byte(i[0] ? 8'h00 : 8'hFF, 1'b0);
    endtask

    // two-byte pattern with the offset wrapping past the top; no second report
    task automatic test_offset_wrap();
        settle_idle();
        write_reg(REG_PATTERN_NIBBLES, {48'h0, PAT_TRAIL_BYTE, PAT_LEAD_BYTE});
        write_reg(REG_NIBBLE_CARE_MASK, 64'hFFFF);
        write_reg(REG_PATTERN_LENGTH, 64'd2);
        write_reg(REG_BASE_OFFSET, 64'hFFFF_FFFF);
        send_byte(8'h00, 1'b1);
        send_byte(PAT_LEAD_BYTE, 1'b0);
        send_byte(PAT_TRAIL_BYTE, 1'b0);
        send_byte(PAT_LEAD_BYTE, 1'b0);
        send_byte(PAT_TRAIL_BYTE, 1'b0);
    endtask

    // zero length acts as one; single nibble compares; spare index ignored
    task automatic test_nibble_wildcards();
        settle_idle();
        write_reg(REG_PATTERN_LENGTH, 64'd0);
        write_reg(REG_NIBBLE_CARE_MASK, 64'h0002);
        write_reg(CFG_INDEX_SPARE, '1);
        send_byte(8'h47, 1'b1);
        send_byte(8'h3C, 1'b0);
        settle_idle();
        write_reg(REG_NIBBLE_CARE_MASK, 64'h0001);
        send_byte(8'h07, 1'b1);
    endtask

    // random phases: mostly whole patterns with random wildcard content,
    // some cut-off patterns and plain noise
    task automatic test_random_phases();
        int          ph;
        int          target;
        int          kind;
        int          n;
        int          i;
        int unsigned span;
        logic        rs;
        logic [63:0] val;
        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            settle_idle();
            idle_on = ($urandom_range(0, 3) != 0);
            case (ph)
                0:
                begin
                    write_reg(REG_PATTERN_NIBBLES, '1);
                    write_reg(REG_NIBBLE_CARE_MASK, 64'hFFFF);
                    write_reg(REG_PATTERN_LENGTH, 64'd8);
                    write_reg(REG_BASE_OFFSET, 64'hFFFF_FFF0);
                end
                1:
                begin
                    write_reg(REG_PATTERN_NIBBLES, '0);
                    write_reg(REG_NIBBLE_CARE_MASK, 64'h5555);
                    write_reg(REG_PATTERN_LENGTH, 64'd1);
                    write_reg(REG_BASE_OFFSET, 64'h0);
                end
                default:
                begin
                    kind = $urandom_range(0, 3);
                    val  = (kind == 0) ? '0 : (kind == 1) ? '1 : {$urandom, $urandom};
                    write_reg(REG_PATTERN_NIBBLES, val);
                    kind = $urandom_range(0, 3);
                    val  = {$urandom, $urandom};
                    if (kind == 0)
                        val[15:0] = 16'h0000;
                    else if (kind == 1)
                        val[15:0] = 16'hFFFF;
                    write_reg(REG_NIBBLE_CARE_MASK, val);
                    val = {$urandom, $urandom};
                    val[3:0] = 4'($urandom_range(0, 15));
                    write_reg(REG_PATTERN_LENGTH, val);
                    kind = $urandom_range(0, 3);
                    val  = {$urandom, $urandom};
                    if (kind == 0)
                        val[31:0] = 32'h0;
                    else if (kind == 1)
                        val[31:0] = 32'hFFFF_FFFF;
                    write_reg(REG_BASE_OFFSET, val);
                    if ($urandom_range(0, 4) == 0)
                        write_reg(CFG_INDEX_SPARE, {$urandom, $urandom});
                end
            endcase
            span   = window_span();
            target = bytes_sent + PHASE_WORDS;
            while (bytes_sent < target)
            begin
                kind = $urandom_range(0, 9);
                rs   = ($urandom_range(0, 1) == 1);
                if (kind <= 6)
                begin
                    // noise lead-in, then a full pattern
                    n = $urandom_range(0, span);
                    for (i = 0; i < n; i++)
                    begin
                        send_byte(8'($urandom_range(0, 255)), rs);
                        rs = 1'b0;
                    end
                    for (i = 0; i < span; i++)
                    begin
                        send_byte(fit_pattern_byte(i), rs);
                        rs = 1'b0;
                    end
                end
                else if (kind <= 8)
                begin
                    // pattern broken off early
                    n = $urandom_range(0, span - 1);
                    for (i = 0; i < n; i++)
                    begin
                        send_byte(fit_pattern_byte(i), rs);
                        rs = 1'b0;
                    end
                    send_byte(8'($urandom_range(0, 255)), rs);
                end
                else
                begin
                    n = $urandom_range(1, 12);
                    for (i = 0; i < n; i++)
                        send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, checks each accepted word
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int  hold;
        bit  got;
        result_stall = 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            hold = idle_on ? $urandom_range(0, 8) : 0;
            if (hold != 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                result_stall <= 1'b0;
            end
            got = 1'b0;
            while (!got)
            begin
                @(negedge clk);
                if (result_valid === 1'b1 && result_stall == 1'b0)
                begin
                    got = 1'b1;
                    check_result(result_data);
                end
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int i;
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        byte_valid   = 1'b0;
        byte_data    = '0;
        err_count    = 0;
        bytes_sent   = 0;
        results_seen = 0;
        idle_on      = 1'b1;
        pat_bytes    = '0;
        care_bits    = '0;
        pat_len_reg  = 4'd1;
        base_off     = '0;
        count_seen   = '0;
        found_seen   = 1'b0;
        for (i = 0; i < WIN_BYTES; i++)
            win_hist[i] = 8'h00;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_short_stream();
        test_offset_wrap();
        test_nibble_wildcards();
        test_random_phases();

        settle_idle();
        repeat (8) @(posedge clk);
        if (err_count == 0 && search_expect_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // run limit, far above the slowest legal run
    initial
    begin : watchdog
        #2_000_000;
        $display("ERROR: run limit reached with %0d words pending", search_expect_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
